// ===== sv/ljpe_pkg.sv =====
package ljpe_pkg;

   localparam int NUM_TYPES = 128;
   localparam int TYPE_W    = 8;
   localparam int TYPE_AW   = (NUM_TYPES > 1) ? $clog2(NUM_TYPES) : 1;

   localparam int RAD_W = 20;
   localparam int DEP_W = 16;
   localparam int SCL_W = 16;
   localparam int D2_W  = 32;
   localparam int FRAC_SCL = 12;

   localparam int SUM_W = RAD_W + 1;
   localparam int RP_W  = SUM_W + SCL_W;
   localparam int R_W   = RP_W - FRAC_SCL;
   localparam int RSQ_W = 2 * R_W;
   localparam int PD_W  = 2 * DEP_W;

   localparam int QUO_W  = RSQ_W;
   localparam int DEN_W  = D2_W;
   localparam int SQ_W   = D2_W + 16;
   localparam int ROOT_W = SQ_W / 2;

   localparam int MAG_W    = 63;
   localparam int ENERGY_W = 48;

   localparam int DIV_LAT  = QUO_W;
   localparam int SQRT_LAT = ROOT_W;
   localparam int MUL_LAT  = 2;

   localparam int REQ_DATA_W = 88;
   localparam int REQ_USER_W = 1;
   localparam int RSP_DATA_W = 48;
   localparam int RSP_USER_W = 2;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_ENERGY_SCALE     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RADIUS_SCALE     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_REPULSION_SCALE  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ATTRACTION_SCALE = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_LINEAR_DAMPING   = 3'd4;

   localparam logic [SCL_W-1:0] SCALE_ONE = 16'd4096;

   localparam logic [MAG_W-1:0] MAG_CAP = MAG_W'(1) << (MAG_W - 1);
   localparam logic [MAG_W-1:0] E_POS_MAX = (MAG_W'(1) << (ENERGY_W - 1)) - MAG_W'(1);
   localparam logic [MAG_W-1:0] E_NEG_MAX = MAG_W'(1) << (ENERGY_W - 1);

   typedef struct packed {
      logic             big;
      logic [MAG_W-1:0] v;
   } mag_type;

   typedef enum logic {
      SHIFT_12,
      SHIFT_16
   } shift_type;

   typedef struct packed {
      logic vld;
      logic ev;
      logic tv;
   } side_type;

endpackage

// ===== sv/ljpe_table.sv =====
module ljpe_table (
   input  logic                          clock,
   input  logic                          en,
   input  logic                          we,
   input  logic [ljpe_pkg::TYPE_AW-1:0]  waddr,
   input  logic [ljpe_pkg::RAD_W-1:0]    wradius,
   input  logic [ljpe_pkg::DEP_W-1:0]    wdepth,
   input  logic [ljpe_pkg::TYPE_AW-1:0]  raddr_a,
   input  logic [ljpe_pkg::TYPE_AW-1:0]  raddr_b,
   output logic [ljpe_pkg::RAD_W-1:0]    ra,
   output logic [ljpe_pkg::RAD_W-1:0]    rb,
   output logic [ljpe_pkg::DEP_W-1:0]    da,
   output logic [ljpe_pkg::DEP_W-1:0]    db
);
   import ljpe_pkg::*;

   logic [RAD_W+DEP_W-1:0] entry_mem [NUM_TYPES];
   logic [RAD_W+DEP_W-1:0] rd_a_ff;
   logic [RAD_W+DEP_W-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         entry_mem[waddr] <= {wdepth, wradius};
      end
      if (en) begin
         rd_a_ff <= entry_mem[raddr_a];
         rd_b_ff <= entry_mem[raddr_b];
      end
   end

   assign ra = rd_a_ff[RAD_W-1:0];
   assign rb = rd_b_ff[RAD_W-1:0];
   assign da = rd_a_ff[RAD_W+DEP_W-1:RAD_W];
   assign db = rd_b_ff[RAD_W+DEP_W-1:RAD_W];

endmodule

// ===== sv/ljpe_div.sv =====
module ljpe_div (
   input  logic                        clock,
   input  logic                        en,
   input  logic [ljpe_pkg::QUO_W-1:0]  num,
   input  logic [ljpe_pkg::DEN_W-1:0]  den,
   output logic [ljpe_pkg::QUO_W-1:0]  quo
);
   import ljpe_pkg::*;

   logic [DEN_W-1:0] rem_ff [QUO_W];
   logic [QUO_W-1:0] nq_ff  [QUO_W];
   logic [DEN_W-1:0] den_ff [QUO_W];
   logic [DEN_W-1:0] rem_in [QUO_W];
   logic [QUO_W-1:0] nq_in  [QUO_W];
   logic [DEN_W-1:0] den_in [QUO_W];

   always_comb begin
      logic [DEN_W-1:0] rp;
      logic [QUO_W-1:0] np;
      logic [DEN_W-1:0] dp;
      logic [DEN_W:0]   t;
      logic             ge;
      for (int k = 0; k < QUO_W; k++) begin
         if (k == 0) begin
            rp = '0;
            np = num;
            dp = den;
         end else begin
            rp = rem_ff[k-1];
            np = nq_ff[k-1];
            dp = den_ff[k-1];
         end
         t  = {rp, np[QUO_W-1]};
         ge = t >= {1'b0, dp};
         rem_in[k] = ge ? DEN_W'(t - {1'b0, dp}) : t[DEN_W-1:0];
         nq_in[k]  = {np[QUO_W-2:0], ge};
         den_in[k] = dp;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < QUO_W; k++) begin
            rem_ff[k] <= rem_in[k];
            nq_ff[k]  <= nq_in[k];
            den_ff[k] <= den_in[k];
         end
      end
   end

   assign quo = nq_ff[QUO_W-1];

endmodule

// ===== sv/ljpe_sqrt.sv =====
module ljpe_sqrt (
   input  logic                         clock,
   input  logic                         en,
   input  logic [ljpe_pkg::SQ_W-1:0]    x,
   output logic [ljpe_pkg::ROOT_W-1:0]  root
);
   import ljpe_pkg::*;

   logic [ROOT_W:0]   rem_ff  [ROOT_W];
   logic [ROOT_W-1:0] root_ff [ROOT_W];
   logic [SQ_W-1:0]   xs_ff   [ROOT_W];
   logic [ROOT_W:0]   rem_in  [ROOT_W];
   logic [ROOT_W-1:0] root_in [ROOT_W];
   logic [SQ_W-1:0]   xs_in   [ROOT_W];

   always_comb begin
      logic [ROOT_W:0]   rp;
      logic [ROOT_W-1:0] qp;
      logic [SQ_W-1:0]   xp;
      logic [ROOT_W+2:0] t;
      logic [ROOT_W+2:0] trial;
      logic              ge;
      for (int k = 0; k < ROOT_W; k++) begin
         if (k == 0) begin
            rp = '0;
            qp = '0;
            xp = x;
         end else begin
            rp = rem_ff[k-1];
            qp = root_ff[k-1];
            xp = xs_ff[k-1];
         end
         t     = {rp, xp[SQ_W-1:SQ_W-2]};
         trial = {1'b0, qp, 2'b01};
         ge    = t >= trial;
         rem_in[k]  = ge ? (ROOT_W+1)'(t - trial) : t[ROOT_W:0];
         root_in[k] = {qp[ROOT_W-2:0], ge};
         xs_in[k]   = {xp[SQ_W-3:0], 2'b00};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < ROOT_W; k++) begin
            rem_ff[k]  <= rem_in[k];
            root_ff[k] <= root_in[k];
            xs_ff[k]   <= xs_in[k];
         end
      end
   end

   assign root = root_ff[ROOT_W-1];

endmodule

// ===== sv/ljpe_mmul.sv =====
module ljpe_mmul (
   input  logic                 clock,
   input  logic                 en,
   input  ljpe_pkg::mag_type    a,
   input  ljpe_pkg::mag_type    b,
   input  ljpe_pkg::shift_type  shift,
   output ljpe_pkg::mag_type    r
);
   import ljpe_pkg::*;

   localparam int PROD_W = 2 * MAG_W;

   logic [63:0]  p0_ff, p1_ff, p2_ff, p3_ff;
   logic [63:0]  p0_in, p1_in, p2_in, p3_in;
   logic         zero_ff;
   logic         big_ff;
   shift_type    sh_ff;
   logic [PROD_W-1:0] full;
   logic [PROD_W-1:0] shd;
   mag_type      r_ff;
   mag_type      r_in;

   assign p0_in = a.v[31:0] * b.v[31:0];
   assign p1_in = a.v[31:0] * b.v[MAG_W-1:32];
   assign p2_in = a.v[MAG_W-1:32] * b.v[31:0];
   assign p3_in = a.v[MAG_W-1:32] * b.v[MAG_W-1:32];

   always_ff @(posedge clock) begin
      if (en) begin
         p0_ff   <= p0_in;
         p1_ff   <= p1_in;
         p2_ff   <= p2_in;
         p3_ff   <= p3_in;
         zero_ff <= (a.v == '0) || (b.v == '0);
         big_ff  <= a.big || b.big;
         sh_ff   <= shift;
      end
   end

   always_comb begin
      full = PROD_W'(p0_ff) + (PROD_W'(p1_ff) << 32) + (PROD_W'(p2_ff) << 32)
           + (PROD_W'(p3_ff) << 64);
      case (sh_ff)
         SHIFT_16: shd = full >> 16;
         default:  shd = full >> FRAC_SCL;
      endcase
      if (zero_ff) begin
         r_in = '0;
      end else if (big_ff || (|shd[PROD_W-1:MAG_W-1])) begin
         r_in.big = 1'b1;
         r_in.v   = MAG_CAP;
      end else begin
         r_in.big = 1'b0;
         r_in.v   = shd[MAG_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         r_ff <= r_in;
      end
   end

   assign r = r_ff;

endmodule

// ===== sv/lennard_jones_pair_energy.sv =====
// Channel   Direction  Handshake              Contents
// req       in         req_tvalid/req_tready  table write or pair evaluation
// rsp       out        rsp_tvalid/rsp_tready  pair energy and status flags
// csr       in         csr_valid/csr_ready    scale and mode registers
//
// One word is accepted per cycle while no result is stalled. The pipeline length
// is set by the close-range path: a 24-step square root followed by a 50-step
// divider, with the long-range divider and multipliers aligned to it.
// Reset clears the valid bits and sets the scales to one and damping off; the table is not cleared.
// A stalled result freezes the whole pipeline, so nothing is lost or repeated.
module lennard_jones_pair_energy (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // type_a, type_b, distance_sq, entry_radius, entry_depth, zero fill
   input  logic [ljpe_pkg::REQ_DATA_W-1:0]    req_tdata,
   // func
   input  logic [ljpe_pkg::REQ_USER_W-1:0]    req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // energy
   output logic [ljpe_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // type_valid, saturated
   output logic [ljpe_pkg::RSP_USER_W-1:0]    rsp_tuser,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [ljpe_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [ljpe_pkg::CSR_DATA_W-1:0]    csr_data
);
   import ljpe_pkg::*;

   localparam int LJ0_T   = DIV_LAT + 4 * MUL_LAT + 1;
   localparam int LIN_T   = SQRT_LAT + DIV_LAT + 2;
   localparam int EPS_DLY = LJ0_T - SQRT_LAT;
   localparam int NEG_DLY = LIN_T - LJ0_T;
   localparam int ELJ_DLY = LIN_T - LJ0_T - MUL_LAT;
   localparam int SIDE_DLY = LIN_T + MUL_LAT;

   logic [SCL_W-1:0] energy_scale_ff, radius_scale_ff;
   logic [SCL_W-1:0] repulsion_scale_ff, attraction_scale_ff;
   logic             linear_damping_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         energy_scale_ff     <= SCALE_ONE;
         radius_scale_ff     <= SCALE_ONE;
         repulsion_scale_ff  <= SCALE_ONE;
         attraction_scale_ff <= SCALE_ONE;
         linear_damping_ff   <= 1'b0;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_ENERGY_SCALE:     energy_scale_ff     <= csr_data;
            CSR_RADIUS_SCALE:     radius_scale_ff     <= csr_data;
            CSR_REPULSION_SCALE:  repulsion_scale_ff  <= csr_data;
            CSR_ATTRACTION_SCALE: attraction_scale_ff <= csr_data;
            CSR_LINEAR_DAMPING:   linear_damping_ff   <= csr_data[0];
            default: ;
         endcase
      end
   end

   assign csr_ready = 1'b1;

   logic              adv;
   logic              acc;
   logic              in_func;
   logic [TYPE_W-1:0] in_ta, in_tb;
   logic [D2_W-1:0]   in_d2;
   logic [RAD_W-1:0]  in_radius;
   logic [DEP_W-1:0]  in_depth;
   logic              ok_a, ok_b;
   side_type          side_in;
   logic              rsp_tvalid_ff;

   assign adv        = !rsp_tvalid_ff || rsp_tready;
   assign req_tready = adv;
   assign acc        = req_tvalid && adv;

   assign in_func   = req_tuser[0];
   assign in_ta     = req_tdata[7:0];
   assign in_tb     = req_tdata[15:8];
   assign in_d2     = req_tdata[47:16];
   assign in_radius = req_tdata[67:48];
   assign in_depth  = req_tdata[83:68];

   assign ok_a = {1'b0, in_ta} < (TYPE_W+1)'(NUM_TYPES);
   assign ok_b = {1'b0, in_tb} < (TYPE_W+1)'(NUM_TYPES);

   assign side_in.vld = acc;
   assign side_in.ev  = in_func && ok_a && ok_b;
   assign side_in.tv  = in_func ? (ok_a && ok_b) : ok_a;

   logic [RAD_W-1:0] ra, rb;
   logic [DEP_W-1:0] da, db;

   ljpe_table u_table (
      .clock   (clock),
      .en      (adv),
      .we      (acc && !in_func && ok_a),
      .waddr   (in_ta[TYPE_AW-1:0]),
      .wradius (in_radius),
      .wdepth  (in_depth),
      .raddr_a (in_ta[TYPE_AW-1:0]),
      .raddr_b (in_tb[TYPE_AW-1:0]),
      .ra      (ra),
      .rb      (rb),
      .da      (da),
      .db      (db)
   );

   side_type        sa_ff, sb_ff, sc_ff;
   logic [D2_W-1:0] d2a_ff, d2b_ff, d2c_ff;
   logic [SUM_W-1:0] sum_ab;
   logic [RP_W-1:0]  rp_ff, rp_in;
   logic [PD_W-1:0]  pd_ff, pd_in, pdc_ff;
   logic [R_W-1:0]   r_c, rc_ff;
   logic [RSQ_W-1:0] rsq_ff, rsq_in;

   assign sum_ab = SUM_W'(ra) + SUM_W'(rb);
   assign rp_in  = RP_W'(sum_ab) * RP_W'(radius_scale_ff);
   assign pd_in  = PD_W'(da) * PD_W'(db);
   assign r_c    = rp_ff[RP_W-1:FRAC_SCL];
   assign rsq_in = RSQ_W'(r_c) * RSQ_W'(r_c);

   always_ff @(posedge clock) begin
      if (reset) begin
         sa_ff <= '0;
         sb_ff <= '0;
         sc_ff <= '0;
      end else if (adv) begin
         sa_ff <= side_in;
         sb_ff <= sa_ff;
         sc_ff <= sb_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         d2a_ff <= (in_d2 == '0) ? D2_W'(1) : in_d2;
         d2b_ff <= d2a_ff;
         d2c_ff <= d2b_ff;
         rp_ff  <= rp_in;
         pd_ff  <= pd_in;
         pdc_ff <= pd_ff;
         rc_ff  <= r_c;
         rsq_ff <= rsq_in;
      end
   end

   logic [QUO_W-1:0]  q;
   logic [ROOT_W-1:0] eps_root, d_root;
   logic [55:0]       cmp_lhs, cmp_rhs;
   logic              dmp_now;

   ljpe_div u_div_lj (
      .clock (clock),
      .en    (adv),
      .num   (rsq_ff),
      .den   (d2c_ff),
      .quo   (q)
   );

   ljpe_sqrt u_sqrt_eps (
      .clock (clock),
      .en    (adv),
      .x     (SQ_W'(pdc_ff)),
      .root  (eps_root)
   );

   ljpe_sqrt u_sqrt_d (
      .clock (clock),
      .en    (adv),
      .x     ({d2c_ff, 16'b0}),
      .root  (d_root)
   );

   assign cmp_lhs = 56'(rsq_ff) * 56'd25;
   assign cmp_rhs = 56'({d2c_ff, 16'b0}) * 56'd28;
   assign dmp_now = linear_damping_ff && (cmp_lhs >= cmp_rhs);

   logic             dmp_dl_ff  [LIN_T];
   logic [R_W-1:0]   r_dl_ff    [SQRT_LAT];
   side_type         side_dl_ff [SIDE_DLY];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < SIDE_DLY; k++) begin
            side_dl_ff[k] <= '0;
         end
      end else if (adv) begin
         side_dl_ff[0] <= sc_ff;
         for (int k = 1; k < SIDE_DLY; k++) begin
            side_dl_ff[k] <= side_dl_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dmp_dl_ff[0] <= dmp_now;
         for (int k = 1; k < LIN_T; k++) begin
            dmp_dl_ff[k] <= dmp_dl_ff[k-1];
         end
         r_dl_ff[0] <= rc_ff;
         for (int k = 1; k < SQRT_LAT; k++) begin
            r_dl_ff[k] <= r_dl_ff[k-1];
         end
      end
   end

   logic [QUO_W-1:0] lnum_ff, lnum_in;
   logic [DEN_W-1:0] lden_ff;
   logic [QUO_W-1:0] lq;
   logic [QUO_W:0]   lin_s;
   logic [QUO_W:0]   lin_abs;
   logic             lin_neg_ff;
   mag_type          lin_mag_ff;

   assign lnum_in = QUO_W'(d_root) * QUO_W'(56);

   always_ff @(posedge clock) begin
      if (adv) begin
         lnum_ff <= lnum_in << 16;
         lden_ff <= DEN_W'(r_dl_ff[SQRT_LAT-1]) * DEN_W'(5);
      end
   end

   ljpe_div u_div_lin (
      .clock (clock),
      .en    (adv),
      .num   (lnum_ff),
      .den   (lden_ff),
      .quo   (lq)
   );

   assign lin_s   = (QUO_W+1)'(655360) - {1'b0, lq};
   assign lin_abs = lin_s[QUO_W] ? (QUO_W+1)'(-lin_s) : lin_s;

   always_ff @(posedge clock) begin
      if (adv) begin
         lin_neg_ff     <= lin_s[QUO_W];
         lin_mag_ff.big <= 1'b0;
         lin_mag_ff.v   <= MAG_W'(lin_abs);
      end
   end

   mag_type q_mag, q2, q3, q6, att, rep, eps_mag, elj, rep_k, att_k;
   mag_type qd_ff  [MUL_LAT];
   mag_type attd_ff [MUL_LAT];
   logic [ROOT_W-1:0] eps_dl_ff [EPS_DLY];

   assign q_mag.big = 1'b0;
   assign q_mag.v   = MAG_W'(q);
   assign rep_k.big = 1'b0;
   assign rep_k.v   = MAG_W'(repulsion_scale_ff);
   assign att_k.big = 1'b0;
   assign att_k.v   = MAG_W'({attraction_scale_ff, 1'b0});

   always_ff @(posedge clock) begin
      if (adv) begin
         qd_ff[0]   <= q_mag;
         attd_ff[0] <= att;
         for (int k = 1; k < MUL_LAT; k++) begin
            qd_ff[k]   <= qd_ff[k-1];
            attd_ff[k] <= attd_ff[k-1];
         end
         eps_dl_ff[0] <= eps_root;
         for (int k = 1; k < EPS_DLY; k++) begin
            eps_dl_ff[k] <= eps_dl_ff[k-1];
         end
      end
   end

   ljpe_mmul u_mul_q2 (
      .clock (clock), .en (adv), .a (q_mag), .b (q_mag), .shift (SHIFT_16), .r (q2)
   );
   ljpe_mmul u_mul_q3 (
      .clock (clock), .en (adv), .a (q2), .b (qd_ff[MUL_LAT-1]), .shift (SHIFT_16), .r (q3)
   );
   ljpe_mmul u_mul_q6 (
      .clock (clock), .en (adv), .a (q3), .b (q3), .shift (SHIFT_16), .r (q6)
   );
   ljpe_mmul u_mul_att (
      .clock (clock), .en (adv), .a (q3), .b (att_k), .shift (SHIFT_12), .r (att)
   );
   ljpe_mmul u_mul_rep (
      .clock (clock), .en (adv), .a (q6), .b (rep_k), .shift (SHIFT_12), .r (rep)
   );

   mag_type lj_ff, lj_in, attd;
   logic    ljneg_ff, ljneg_in;

   assign attd = attd_ff[MUL_LAT-1];

   always_comb begin
      lj_in    = '0;
      ljneg_in = 1'b0;
      if (rep.big) begin
         lj_in = rep;
      end else if (attd.big) begin
         lj_in    = attd;
         ljneg_in = 1'b1;
      end else if (rep.v >= attd.v) begin
         lj_in.v = rep.v - attd.v;
      end else begin
         lj_in.v  = attd.v - rep.v;
         ljneg_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         lj_ff    <= lj_in;
         ljneg_ff <= ljneg_in;
      end
   end

   assign eps_mag.big = 1'b0;
   assign eps_mag.v   = MAG_W'(eps_dl_ff[EPS_DLY-1]);

   ljpe_mmul u_mul_eps (
      .clock (clock), .en (adv), .a (lj_ff), .b (eps_mag), .shift (SHIFT_16), .r (elj)
   );

   logic    ljneg_dl_ff [NEG_DLY];
   mag_type elj_dl_ff   [ELJ_DLY];

   always_ff @(posedge clock) begin
      if (adv) begin
         ljneg_dl_ff[0] <= ljneg_ff;
         for (int k = 1; k < NEG_DLY; k++) begin
            ljneg_dl_ff[k] <= ljneg_dl_ff[k-1];
         end
         elj_dl_ff[0] <= elj;
         for (int k = 1; k < ELJ_DLY; k++) begin
            elj_dl_ff[k] <= elj_dl_ff[k-1];
         end
      end
   end

   logic    use_lin;
   mag_type fe, es_mag, ef;
   logic    fneg;
   logic    fneg_dl_ff [MUL_LAT];

   assign use_lin    = dmp_dl_ff[LIN_T-1];
   assign fe         = use_lin ? lin_mag_ff : elj_dl_ff[ELJ_DLY-1];
   assign fneg       = use_lin ? lin_neg_ff : ljneg_dl_ff[NEG_DLY-1];
   assign es_mag.big = 1'b0;
   assign es_mag.v   = MAG_W'(energy_scale_ff);

   ljpe_mmul u_mul_scale (
      .clock (clock), .en (adv), .a (fe), .b (es_mag), .shift (SHIFT_12), .r (ef)
   );

   always_ff @(posedge clock) begin
      if (adv) begin
         fneg_dl_ff[0] <= fneg;
         for (int k = 1; k < MUL_LAT; k++) begin
            fneg_dl_ff[k] <= fneg_dl_ff[k-1];
         end
      end
   end

   side_type              so;
   logic                  eneg;
   logic [ENERGY_W-1:0]   energy_ff, energy_in;
   logic                  tv_ff, sat_ff, sat_in;

   assign so   = side_dl_ff[SIDE_DLY-1];
   assign eneg = fneg_dl_ff[MUL_LAT-1];

   always_comb begin
      energy_in = '0;
      sat_in    = 1'b0;
      if (so.ev) begin
         if (!eneg) begin
            if (ef.big || (ef.v > E_POS_MAX)) begin
               energy_in = E_POS_MAX[ENERGY_W-1:0];
               sat_in    = 1'b1;
            end else begin
               energy_in = ef.v[ENERGY_W-1:0];
            end
         end else begin
            if (ef.big || (ef.v > E_NEG_MAX)) begin
               energy_in = E_NEG_MAX[ENERGY_W-1:0];
               sat_in    = 1'b1;
            end else begin
               energy_in = ENERGY_W'(-ef.v[ENERGY_W-1:0]);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (adv) begin
         rsp_tvalid_ff <= so.vld;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         energy_ff <= energy_in;
         tv_ff     <= so.tv;
         sat_ff    <= sat_in;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = energy_ff;
   assign rsp_tuser  = {sat_ff, tv_ff};

`ifndef SYNTHESIS
   a_stall_blocks_input: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |-> !req_tready)
      else $error("input word taken while result stalled");

   a_reset_empties: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid straight after reset");

   a_bad_type_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser[0]) |-> (rsp_tdata == '0 && !rsp_tuser[1]))
      else $error("out-of-table word carries energy or saturation");

   a_sat_extreme: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[1]) |->
         (rsp_tdata == E_POS_MAX[ENERGY_W-1:0] || rsp_tdata == E_NEG_MAX[ENERGY_W-1:0]))
      else $error("saturated energy is not at a range limit");
`endif

endmodule
